@@ sv/cbsp_pkg.sv @@
package cbsp_pkg;

    localparam int SEG_W     = 6;
    localparam int T_PARAM_W = 17;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 24;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;
    localparam logic [1:0] ST_SEG  = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Floor division by six: offset to make the value positive, halve, then
    // multiply by the rounded-up reciprocal of three.
    localparam int          DIV_V_W      = 31;
    localparam int          DIV_H_W      = 28;
    localparam int          DIV_Q_W      = 27;
    localparam int          DIV_R_W      = 28;
    localparam logic [30:0] DIV_OFFSET   = 31'd402653184;
    localparam logic [DIV_R_W-1:0] DIV_OFFSET_Q = 28'd67108864;
    localparam logic [28:0] RECIP3       = 29'd357913942;
    localparam int          RECIP3_SHIFT = 30;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    typedef struct packed {
        logic [1:0]                 operation;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic [SEG_W-1:0]           segment;
        logic [T_PARAM_W-1:0]       t_param;
    } t_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic [1:0]              status;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef enum logic [1:0] {
        K_NOP,
        K_CLEAR,
        K_APPEND,
        K_EVAL
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [1:0]           status;
        t_point               point;
        logic [SEG_W-1:0]     segment;
        logic [T_PARAM_W-1:0] t_param;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_T2,
        BK_T3,
        BK_WGT,
        BK_MAC,
        BK_SCALE,
        BK_DIV,
        BK_OUT
    } t_bk_state;

endpackage

@@ sv/cbsp_ram.sv @@
module cbsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cbsp_front.sv @@
module cbsp_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  cbsp_pkg::t_req i_req,
    input  logic           i_full,
    output logic           o_busy,
    output logic           o_push,
    output cbsp_pkg::t_cmd o_cmd
);
    import cbsp_pkg::*;

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SW   = (SEG_W > CNTW) ? SEG_W : CNTW;

    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;
    logic            w_accept;

    assign w_accept = i_start && !i_full;
    assign o_busy   = i_full;
    assign o_push   = w_accept;

    always_comb begin
        n_count         = r_count;
        o_cmd.kind      = K_NOP;
        o_cmd.status    = ST_OK;
        o_cmd.point.x   = i_req.px;
        o_cmd.point.y   = i_req.py;
        o_cmd.point.z   = i_req.pz;
        o_cmd.segment   = i_req.segment;
        o_cmd.t_param   = i_req.t_param;
        unique case (i_req.operation)
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
                n_count    = '0;
            end
            OP_APPEND: begin
                if (r_count >= CNTW'(MAX_POINTS)) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.kind = K_APPEND;
                    n_count    = r_count + CNTW'(1);
                end
            end
            OP_EVAL: begin
                if (r_count < CNTW'(4)) begin
                    o_cmd.status = ST_FEW;
                end else if (SW'(i_req.segment) >= SW'(r_count)) begin
                    o_cmd.status = ST_SEG;
                end else begin
                    o_cmd.kind = K_EVAL;
                end
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

endmodule

@@ sv/cbsp_queue.sv @@
module cbsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbsp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output cbsp_pkg::t_cmd o_head
);
    import cbsp_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_fill;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + (Q_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ sv/cbsp_back.sv @@
module cbsp_back #(
    parameter int MAX_POINTS  = 64,
    parameter int T_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  cbsp_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_done,
    output cbsp_pkg::t_result o_result
);
    import cbsp_pkg::*;

    localparam int          ADW  = $clog2(MAX_POINTS);
    localparam int          CNTW = $clog2(MAX_POINTS + 1);
    localparam int          F    = T_FRAC_BITS;
    localparam int          TW   = F + 1;
    localparam int          CW   = (T_PARAM_W > TW) ? T_PARAM_W : TW;
    localparam int          WW   = F + 5;
    localparam int          PW   = COORD_W + WW;
    localparam int          ACW  = F + 23;
    localparam int unsigned ONE  = 1 << F;
    localparam logic signed [WW-1:0] C3 = WW'(3);
    localparam logic signed [WW-1:0] C4 = WW'(4);
    localparam logic signed [WW-1:0] C6 = WW'(6);

    t_bk_state r_state;
    t_bk_state n_state;

    logic [CNTW-1:0]          r_count;
    logic [CNTW-1:0]          n_count;
    logic [ADW-1:0]           r_idx;
    logic [ADW-1:0]           n_idx;
    logic [1:0]               r_k;
    logic [1:0]               n_k;
    logic [TW-1:0]            r_t;
    logic [TW-1:0]            n_t;
    logic [TW-1:0]            r_t2;
    logic [TW-1:0]            n_t2;
    logic [TW-1:0]            r_t3;
    logic [TW-1:0]            n_t3;
    logic signed [WW-1:0]     r_w [4];
    logic signed [WW-1:0]     n_w [4];
    logic signed [ACW-1:0]    r_acc [3];
    logic signed [ACW-1:0]    n_acc [3];
    logic [DIV_H_W-1:0]       r_h [3];
    logic [DIV_H_W-1:0]       n_h [3];
    logic [DIV_Q_W-1:0]       r_q [3];
    logic [DIV_Q_W-1:0]       n_q [3];
    logic signed [OUT_W-1:0]  w_res [3];
    t_result                  r_out;
    t_result                  n_out;
    logic                     r_done;
    logic                     n_done;

    logic                     w_we;
    logic [ADW-1:0]           w_waddr;
    logic [ADW-1:0]           w_raddr;
    t_point                   w_rdata;
    logic [ADW-1:0]           w_idx_next;
    logic [CNTW-1:0]          w_idx_inc;
    logic [CW-1:0]            w_tin;
    logic [2*TW-1:0]          w_tt;
    logic [2*TW-1:0]          w_t2t;
    logic signed [WW-1:0]     w_ts;
    logic signed [WW-1:0]     w_t2s;
    logic signed [WW-1:0]     w_t3s;
    logic signed [WW-1:0]     w_one;
    logic signed [WW-1:0]     w_wsel;
    logic signed [COORD_W-1:0] w_pc [3];
    logic signed [PW-1:0]     w_prod [3];
    logic signed [ACW+7:0]    w_sh [3];
    logic signed [DIV_V_W-1:0] w_u [3];
    logic [DIV_H_W+28:0]      w_qp [3];
    logic signed [DIV_R_W-1:0] w_r [3];

    cbsp_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.point),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_idx_inc  = CNTW'(r_idx) + CNTW'(1);
    assign w_idx_next = (w_idx_inc == r_count) ? '0 : r_idx + ADW'(1);
    assign w_tin      = CW'(i_cmd.t_param);
    assign w_tt       = (2*TW)'(r_t) * (2*TW)'(r_t);
    assign w_t2t      = (2*TW)'(r_t2) * (2*TW)'(r_t);
    assign w_ts       = WW'(r_t);
    assign w_t2s      = WW'(r_t2);
    assign w_t3s      = WW'(r_t3);
    assign w_one      = WW'(ONE);
    assign w_wsel     = r_w[r_k];
    assign w_pc[0]    = w_rdata.x;
    assign w_pc[1]    = w_rdata.y;
    assign w_pc[2]    = w_rdata.z;
    assign w_waddr    = r_count[ADW-1:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_prod[j] = PW'(w_pc[j]) * PW'(w_wsel);
            w_sh[j]   = $signed({r_acc[j], 8'b0}) >>> F;
            w_u[j]    = w_sh[j][DIV_V_W-1:0] + $signed(DIV_OFFSET);
            w_qp[j]   = (DIV_H_W+29)'(r_h[j]) * (DIV_H_W+29)'(RECIP3);
            w_r[j]    = $signed(DIV_R_W'(r_q[j])) - $signed(DIV_OFFSET_Q);
            if (w_r[j] > DIV_R_W'(OUT_MAX)) begin
                w_res[j] = OUT_MAX;
            end else if (w_r[j] < DIV_R_W'(OUT_MIN)) begin
                w_res[j] = OUT_MIN;
            end else begin
                w_res[j] = w_r[j][OUT_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == K_EVAL) begin
                    n_state = BK_T2;
                end
            end
            BK_T2:    n_state = BK_T3;
            BK_T3:    n_state = BK_WGT;
            BK_WGT:   n_state = BK_MAC;
            BK_MAC: begin
                if (r_k == 2'd3) begin
                    n_state = BK_SCALE;
                end
            end
            BK_SCALE: n_state = BK_DIV;
            BK_DIV:   n_state = BK_OUT;
            BK_OUT:   n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_raddr = r_idx;
        n_count = r_count;
        n_idx   = r_idx;
        n_k     = r_k;
        n_t     = r_t;
        n_t2    = r_t2;
        n_t3    = r_t3;
        n_w     = r_w;
        n_acc   = r_acc;
        n_h     = r_h;
        n_q     = r_q;
        n_out   = r_out;
        n_done  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_EVAL: begin
                            n_idx = ADW'(i_cmd.segment);
                            n_k   = 2'd0;
                            n_t   = (w_tin > CW'(ONE)) ? TW'(ONE) : TW'(w_tin);
                        end
                        K_APPEND: begin
                            w_we    = 1'b1;
                            n_count = r_count + CNTW'(1);
                        end
                        K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                    if (i_cmd.kind != K_EVAL) begin
                        n_done = 1'b1;
                        n_out  = '{out_x: '0, out_y: '0, out_z: '0,
                                   status: i_cmd.status};
                    end
                end
            end
            BK_T2: begin
                n_t2 = TW'(w_tt >> F);
            end
            BK_T3: begin
                n_t3 = TW'(w_t2t >> F);
            end
            BK_WGT: begin
                n_w[3] = w_t3s;
                n_w[2] = w_one + C3 * w_t2s + C3 * w_ts - C3 * w_t3s;
                n_w[1] = C3 * w_t3s - C6 * w_t2s + C4 * w_one;
                n_w[0] = w_one - C3 * w_ts + C3 * w_t2s - w_t3s;
                n_idx  = w_idx_next;
                n_k    = 2'd0;
                for (int j = 0; j < 3; j++) begin
                    n_acc[j] = '0;
                end
            end
            BK_MAC: begin
                n_idx = w_idx_next;
                n_k   = r_k + 2'd1;
                for (int j = 0; j < 3; j++) begin
                    n_acc[j] = r_acc[j] + ACW'(w_prod[j]);
                end
            end
            BK_SCALE: begin
                for (int j = 0; j < 3; j++) begin
                    n_h[j] = w_u[j][DIV_H_W:1];
                end
            end
            BK_DIV: begin
                for (int j = 0; j < 3; j++) begin
                    n_q[j] = w_qp[j][RECIP3_SHIFT +: DIV_Q_W];
                end
            end
            BK_OUT: begin
                n_done = 1'b1;
                n_out  = '{out_x: w_res[0], out_y: w_res[1], out_z: w_res[2],
                           status: ST_OK};
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_t   <= n_t;
        r_t2  <= n_t2;
        r_t3  <= n_t3;
        r_w   <= n_w;
        r_acc <= n_acc;
        r_h   <= n_h;
        r_q   <= n_q;
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

@@ sv/closed_bspline_point_evaluator_top.sv @@
// Channel    Direction  Handshake             Payload
// request    in         start, busy           i_req    (cbsp_pkg::t_req)
// result     out        o_done (one cycle)    o_result (cbsp_pkg::t_result)
//
// A request is taken when start is high and busy is low; busy rises only when
// the four-entry command queue is full. Clear, append and unused operations hold
// the back end only for the dequeue; an evaluation also holds it for the
// t-squared, t-cubed and weight steps, four point reads, scaling, division by
// six and saturation. Reset is synchronous and empties the list; the receiver
// cannot stall.
module closed_bspline_point_evaluator_top #(
    parameter int MAX_POINTS  = 64,
    parameter int T_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cbsp_pkg::t_req    i_req,
    output logic              o_done,
    output cbsp_pkg::t_result o_result
);
    import cbsp_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_valid;
    t_cmd  w_cmd_in;
    t_cmd  w_cmd_head;

    cbsp_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    cbsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_head  (w_cmd_head)
    );

    cbsp_back #(
        .MAX_POINTS  (MAX_POINTS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_valid),
        .i_cmd       (w_cmd_head),
        .o_pop       (w_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
